FILE: hdl/jrls_pkg.sv
// Shared types, constants and rounding helpers for the joystick rate-limit scaler.
package jrls_pkg;

  localparam int unsigned QDepth = 2;
  localparam int unsigned QPtrW  = $clog2(QDepth);
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  localparam logic [16:0] HalfScale  = 17'd16384;
  localparam logic [20:0] DegToMrad  = 21'd1143819;  // 1000*pi/180 in Q16
  localparam logic [15:0] LinLimitRst = 16'd100;
  localparam logic [15:0] AngLimitRst = 16'd300;
  localparam logic [15:0] LinFineRst   = 16'd10;
  localparam logic [15:0] LinCoarseRst = 16'd100;
  localparam logic [15:0] AngFineRst   = 16'd50;
  localparam logic [15:0] AngCoarseRst = 16'd500;
  localparam logic [7:0]  RepeatDelayRst = 8'd20;
  localparam logic [7:0]  HoldMax = 8'd255;

  typedef enum logic [2:0] {
    CFG_LIN_FINE,
    CFG_LIN_COARSE,
    CFG_ANG_FINE,
    CFG_ANG_COARSE,
    CFG_REPEAT_DELAY
  } jrls_cfg_e;

  typedef enum logic [1:0] {
    SEL_NONE,
    SEL_ANG,
    SEL_LIN
  } jrls_sel_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_STEP,
    ST_LIMIT,
    ST_CMD,
    ST_SCALE,
    ST_DONE
  } jrls_state_e;

  typedef struct packed {
    jrls_sel_e          sel;
    logic [15:0]        step;
    logic signed [15:0] dpad;
    logic signed [15:0] lin_stick;
    logic signed [15:0] turn_stick;
  } jrls_req_t;

  // p / 2^15, nearest, halves away from zero
  function automatic logic signed [17:0] round_shr15(input logic signed [32:0] p);
    logic               neg;
    logic [32:0]        mag;
    logic [32:0]        r;
    logic signed [17:0] rs;
    neg = p[32];
    mag = neg ? 33'(-p) : 33'(p);
    r   = (mag + 33'd16384) >> 15;
    rs  = signed'(r[17:0]);
    return neg ? -rs : rs;
  endfunction

  // p / 2^31, nearest, halves away from zero
  function automatic logic signed [21:0] round_shr31(input logic signed [54:0] p);
    logic               neg;
    logic [54:0]        mag;
    logic [54:0]        r;
    logic signed [21:0] rs;
    neg = p[54];
    mag = neg ? 55'(-p) : 55'(p);
    r   = (mag + (55'd1 << 30)) >> 31;
    rs  = signed'(r[21:0]);
    return neg ? -rs : rs;
  endfunction

endpackage

FILE: hdl/jrls_front.sv
// Front end: configuration registers, press detection, auto-repeat and step selection.
module jrls_front import jrls_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [2:0]         cfg_index_i,
  input  logic [15:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [15:0] dpad_axis_i,
  input  logic               cross_button_i,
  input  logic               square_button_i,
  input  logic               circle_button_i,
  input  logic               triangle_button_i,
  input  logic signed [15:0] linear_stick_i,
  input  logic signed [15:0] turn_stick_i,
  output logic               push_valid_o,
  input  logic               push_ready_i,
  output jrls_req_t          push_data_o
);

  logic [15:0] lin_fine_q, lin_coarse_q, ang_fine_q, ang_coarse_q;
  logic [7:0]  repeat_delay_q;
  logic        prev_low_q, prev_low_d;
  logic [7:0]  hold_q, hold_d;
  logic        rep_q, rep_d;

  logic signed [16:0] dpad_ext;
  logic [16:0]        dpad_mag;
  logic               pressed, rise, take;
  logic               in_fire;
  jrls_sel_e          sel;
  logic [15:0]        step;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lin_fine_q     <= LinFineRst;
      lin_coarse_q   <= LinCoarseRst;
      ang_fine_q     <= AngFineRst;
      ang_coarse_q   <= AngCoarseRst;
      repeat_delay_q <= RepeatDelayRst;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_LIN_FINE:     lin_fine_q     <= cfg_data_i;
        CFG_LIN_COARSE:   lin_coarse_q   <= cfg_data_i;
        CFG_ANG_FINE:     ang_fine_q     <= cfg_data_i;
        CFG_ANG_COARSE:   ang_coarse_q   <= cfg_data_i;
        CFG_REPEAT_DELAY: repeat_delay_q <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  assign dpad_ext = {dpad_axis_i[15], dpad_axis_i};
  assign dpad_mag = dpad_ext[16] ? 17'(-dpad_ext) : 17'(dpad_ext);
  assign pressed  = dpad_mag > HalfScale;
  assign rise     = prev_low_q && pressed;
  assign take     = rep_q || rise;

  // priority: cross, square, circle, triangle
  always_comb begin
    sel  = SEL_NONE;
    step = '0;
    if (take) begin
      if (cross_button_i) begin
        sel  = SEL_ANG;
        step = ang_fine_q;
      end else if (square_button_i) begin
        sel  = SEL_ANG;
        step = ang_coarse_q;
      end else if (circle_button_i) begin
        sel  = SEL_LIN;
        step = lin_fine_q;
      end else if (triangle_button_i) begin
        sel  = SEL_LIN;
        step = lin_coarse_q;
      end
    end
  end

  always_comb begin
    hold_d     = hold_q;
    rep_d      = rep_q;
    prev_low_d = dpad_mag < HalfScale;
    if (pressed) begin
      if (!rep_q) begin
        if (hold_q > repeat_delay_q) begin
          rep_d = 1'b1;
        end else if (hold_q != HoldMax) begin
          hold_d = hold_q + 8'd1;
        end
      end
    end else begin
      hold_d = '0;
      rep_d  = 1'b0;
    end
  end

  assign in_fire      = in_valid_i && push_ready_i;
  assign in_ready_o   = push_ready_i;
  assign push_valid_o = in_valid_i;

  assign push_data_o.sel        = sel;
  assign push_data_o.step       = step;
  assign push_data_o.dpad       = dpad_axis_i;
  assign push_data_o.lin_stick  = linear_stick_i;
  assign push_data_o.turn_stick = turn_stick_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_low_q <= 1'b1;
      hold_q     <= '0;
      rep_q      <= 1'b0;
    end else if (in_fire) begin
      prev_low_q <= prev_low_d;
      hold_q     <= hold_d;
      rep_q      <= rep_d;
    end
  end

`ifndef SYNTH
  // repeat is only ever live after a pressed sample
  a_rep_after_press: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rep_q |-> !prev_low_q)
    else $error("auto-repeat active after a released sample");
`endif

endmodule

FILE: hdl/jrls_queue.sv
// Two-entry request queue between the front and back ends.
module jrls_queue import jrls_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_valid_i,
  output logic      push_ready_o,
  input  jrls_req_t push_data_i,
  output logic      pop_valid_o,
  input  logic      pop_ready_i,
  output jrls_req_t pop_data_o
);

  jrls_req_t        mem_q [QDepth];
  logic [QPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCntW-1:0] cnt_q;
  logic             push, pop;

  assign push_ready_o = cnt_q != QCntW'(QDepth);
  assign pop_valid_o  = cnt_q != '0;
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_data_o   = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == QPtrW'(QDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == QPtrW'(QDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      cnt_q <= cnt_q + QCntW'(push) - QCntW'(pop);
    end
  end

endmodule

FILE: hdl/jrls_back.sv
// Back end: limit update and command scaling on a shared multiply sequencer.
module jrls_back import jrls_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               pop_valid_i,
  output logic               pop_ready_o,
  input  jrls_req_t          pop_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [16:0] linear_command_o,
  output logic signed [21:0] angular_command_o,
  output logic [15:0]        linear_limit_now_o,
  output logic [15:0]        angular_limit_now_o
);

  jrls_state_e state_q, state_d;
  jrls_req_t   item_q;

  logic [15:0]        lin_limit_q, ang_limit_q;
  logic signed [32:0] prod_q;
  logic signed [32:0] lin_p_q, ang_p_q;
  logic signed [54:0] ang_k_q;
  logic signed [17:0] lin_cmd_q;
  logic               out_valid_q;
  logic signed [16:0] lin_out_q;
  logic signed [21:0] ang_out_q;
  logic [15:0]        lin_now_q, ang_now_q;

  logic               out_load;
  logic [15:0]        cur_limit, new_limit;
  logic signed [17:0] delta;
  logic signed [18:0] sum_s;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:  if (pop_valid_i) state_d = ST_STEP;
      ST_STEP:  state_d = ST_LIMIT;
      ST_LIMIT: state_d = ST_CMD;
      ST_CMD:   state_d = ST_SCALE;
      ST_SCALE: state_d = ST_DONE;
      ST_DONE:  if (!out_valid_q || out_ready_i) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    pop_ready_o = 1'b0;
    out_load    = 1'b0;
    case (state_q)
      ST_IDLE: pop_ready_o = 1'b1;
      ST_DONE: out_load    = !out_valid_q || out_ready_i;
      default: ;
    endcase
  end

  assign cur_limit = (item_q.sel == SEL_ANG) ? ang_limit_q : lin_limit_q;
  assign delta     = round_shr15(prod_q);
  assign sum_s     = signed'({3'b000, cur_limit}) + 19'(delta);
  assign new_limit = sum_s < 0 ? 16'd0 :
                     (sum_s > 19'sd65535) ? 16'hFFFF : sum_s[15:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      lin_limit_q <= LinLimitRst;
      ang_limit_q <= AngLimitRst;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_LIMIT) begin
        case (item_q.sel)
          SEL_ANG: ang_limit_q <= new_limit;
          SEL_LIN: lin_limit_q <= new_limit;
          default: ;
        endcase
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_ready_o && pop_valid_i) begin
      item_q <= pop_data_i;
    end
    if (state_q == ST_STEP) begin
      prod_q <= signed'({1'b0, item_q.step}) * item_q.dpad;
    end
    if (state_q == ST_CMD) begin
      lin_p_q <= signed'({1'b0, lin_limit_q}) * item_q.lin_stick;
      ang_p_q <= signed'({1'b0, ang_limit_q}) * item_q.turn_stick;
    end
    if (state_q == ST_SCALE) begin
      ang_k_q   <= ang_p_q * signed'({1'b0, DegToMrad});
      lin_cmd_q <= round_shr15(lin_p_q);
    end
    if (out_load) begin
      lin_out_q <= lin_cmd_q[16:0];
      ang_out_q <= round_shr31(ang_k_q);
      lin_now_q <= lin_limit_q;
      ang_now_q <= ang_limit_q;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign linear_command_o    = lin_out_q;
  assign angular_command_o   = ang_out_q;
  assign linear_limit_now_o  = lin_now_q;
  assign angular_limit_now_o = ang_now_q;

`ifndef SYNTH
  a_idle_waits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_IDLE && !pop_valid_i |=> state_q == ST_IDLE)
    else $error("sequencer left idle without a request");

  a_done_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_DONE && (!out_valid_q || out_ready_i) |=> out_valid_q)
    else $error("finished request not presented");

  a_no_sel_keeps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_LIMIT && item_q.sel == SEL_NONE
      |=> $stable(lin_limit_q) && $stable(ang_limit_q))
    else $error("limit changed without a selected adjustment");
`endif

endmodule

FILE: hdl/joystick_rate_limit_scaler_top.sv
// Top level of the joystick rate-limit scaler: front end, request queue, back end.
// Each joystick sample is one request. The front end takes a request in the cycle it
// arrives whenever the two-entry queue has room, detects a d-pad press (rising edge
// past half scale, or every sample once auto-repeat is running) and picks the step
// by button priority cross, square, circle, triangle. The back end works one request
// at a time through a six-step sequence (pop, step multiply, limit update and clamp,
// stick multiplies, degree-to-radian multiply, then load of the output register), and
// takes no new request until the last one has been loaded into the output register,
// which waits for the previous result to be taken. A result waiting in the output
// register does not stop the front end from taking up to three more requests (one
// held in the back end, two in the queue) before the input stalls.
// Limits reset to 100 mm/s and 300 deg/s; both are clamped to 0..65535.
// Configuration writes are always accepted; they must be issued only while no request
// is in flight. Index values 5 to 7 are ignored.
module joystick_rate_limit_scaler_top import jrls_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [2:0]         cfg_index_i,
  input  logic [15:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [15:0] dpad_axis_i,
  input  logic               cross_button_i,
  input  logic               square_button_i,
  input  logic               circle_button_i,
  input  logic               triangle_button_i,
  input  logic signed [15:0] linear_stick_i,
  input  logic signed [15:0] turn_stick_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [16:0] linear_command_o,
  output logic signed [21:0] angular_command_o,
  output logic [15:0]        linear_limit_now_o,
  output logic [15:0]        angular_limit_now_o
);

  // front end to queue
  logic      push_valid, push_ready;
  jrls_req_t push_data;
  // queue to back end
  logic      pop_valid, pop_ready;
  jrls_req_t pop_data;

  jrls_front u_front (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_ready_o       (cfg_ready_o),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .dpad_axis_i       (dpad_axis_i),
    .cross_button_i    (cross_button_i),
    .square_button_i   (square_button_i),
    .circle_button_i   (circle_button_i),
    .triangle_button_i (triangle_button_i),
    .linear_stick_i    (linear_stick_i),
    .turn_stick_i      (turn_stick_i),
    .push_valid_o      (push_valid),
    .push_ready_i      (push_ready),
    .push_data_o       (push_data)
  );

  // decouples classification from the multiply sequence
  jrls_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_data),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (pop_data)
  );

  jrls_back u_back (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .pop_valid_i         (pop_valid),
    .pop_ready_o         (pop_ready),
    .pop_data_i          (pop_data),
    .out_valid_o         (out_valid_o),
    .out_ready_i         (out_ready_i),
    .linear_command_o    (linear_command_o),
    .angular_command_o   (angular_command_o),
    .linear_limit_now_o  (linear_limit_now_o),
    .angular_limit_now_o (angular_limit_now_o)
  );

endmodule

FILE: tb/tb_joystick_rate_limit_scaler_top.sv
// Self-checking testbench for the joystick rate-limit scaler top level.
`timescale 1ns / 100ps

module tb_joystick_rate_limit_scaler_top;
  import jrls_pkg::*;

  // ---------------------------------------------------------------------------
  // Run constants
  // ---------------------------------------------------------------------------
  localparam int QuietLimit    = 4000;  // cycles with no request moving before giving up
  localparam int HoldOffCycles = 250;   // long receiver stall for the back-pressure test
  localparam int DrainCycles   = 16;    // settle time after the last result of a phase
  localparam int MaxReports    = 10;

  // Button masks, ordered {cross, square, circle, triangle}
  localparam int CrossBit    = 3;
  localparam int SquareBit   = 2;
  localparam int CircleBit   = 1;
  localparam int TriangleBit = 0;
  localparam logic [3:0] BtnNone     = 4'b0000;
  localparam logic [3:0] BtnCross    = 4'b1000;
  localparam logic [3:0] BtnSquare   = 4'b0100;
  localparam logic [3:0] BtnCircle   = 4'b0010;
  localparam logic [3:0] BtnTriangle = 4'b0001;

  // Q1.15 values around the press threshold
  localparam logic signed [15:0] AxisMaxPos    = 16'sh7FFF;
  localparam logic signed [15:0] AxisMaxNeg    = 16'sh8000;
  localparam logic signed [15:0] AxisHalf      = 16'sh4000;
  localparam logic signed [15:0] AxisNegHalf   = 16'shC000;
  localparam logic signed [15:0] AxisAbove     = 16'sh4001;
  localparam logic signed [15:0] AxisNegAbove  = 16'shBFFF;
  localparam logic signed [15:0] AxisZero      = 16'sh0000;

  typedef struct packed {
    logic signed [15:0] dpad;
    logic [3:0]         btn;
    logic signed [15:0] lin_stick;
    logic signed [15:0] turn_stick;
  } sample_t;

  typedef struct packed {
    logic signed [16:0] lin_cmd;
    logic signed [21:0] ang_cmd;
    logic [15:0]        lin_now;
    logic [15:0]        ang_now;
  } cmd_t;

  // ---------------------------------------------------------------------------
  // DUT connections
  // ---------------------------------------------------------------------------
  logic               clk_i;
  logic               rst_ni;
  logic               cfg_valid_i;
  logic               cfg_ready_o;
  logic [2:0]         cfg_index_i;
  logic [15:0]        cfg_data_i;
  logic               in_valid_i;
  logic               in_ready_o;
  logic signed [15:0] dpad_axis_i;
  logic               cross_button_i;
  logic               square_button_i;
  logic               circle_button_i;
  logic               triangle_button_i;
  logic signed [15:0] linear_stick_i;
  logic signed [15:0] turn_stick_i;
  logic               out_valid_o;
  logic               out_ready_i;
  logic signed [16:0] linear_command_o;
  logic signed [21:0] angular_command_o;
  logic [15:0]        linear_limit_now_o;
  logic [15:0]        angular_limit_now_o;

  joystick_rate_limit_scaler_top u_top (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_valid_i         (cfg_valid_i),
    .cfg_ready_o         (cfg_ready_o),
    .cfg_index_i         (cfg_index_i),
    .cfg_data_i          (cfg_data_i),
    .in_valid_i          (in_valid_i),
    .in_ready_o          (in_ready_o),
    .dpad_axis_i         (dpad_axis_i),
    .cross_button_i      (cross_button_i),
    .square_button_i     (square_button_i),
    .circle_button_i     (circle_button_i),
    .triangle_button_i   (triangle_button_i),
    .linear_stick_i      (linear_stick_i),
    .turn_stick_i        (turn_stick_i),
    .out_valid_o         (out_valid_o),
    .out_ready_i         (out_ready_i),
    .linear_command_o    (linear_command_o),
    .angular_command_o   (angular_command_o),
    .linear_limit_now_o  (linear_limit_now_o),
    .angular_limit_now_o (angular_limit_now_o)
  );

  // ---------------------------------------------------------------------------
  // Clock: 8 ns period
  // ---------------------------------------------------------------------------
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Predicted block state and register copies. These follow the block's own
  // reset values and are only touched at request acceptance or register write.
  // ---------------------------------------------------------------------------
  logic [15:0]        lin_max_q     = LinLimitRst;
  logic [15:0]        ang_max_q     = AngLimitRst;
  logic signed [15:0] dpad_prev_q   = '0;
  logic [7:0]         hold_cnt_q    = '0;
  logic               repeating_q   = 1'b0;

  logic [15:0]        lin_fine_q    = LinFineRst;
  logic [15:0]        lin_coarse_q  = LinCoarseRst;
  logic [15:0]        ang_fine_q    = AngFineRst;
  logic [15:0]        ang_coarse_q  = AngCoarseRst;
  logic [7:0]         rpt_delay_q   = RepeatDelayRst;

  cmd_t pending_cmds[$];   // commands still owed by the block, oldest first

  int   failures        = 0;
  int   items_sent      = 0;
  int   results_checked = 0;
  int   settings_done   = 0;

  // Idle control: when set, the side never idles of its own accord
  bit   tx_steady = 1'b0;
  bit   rx_steady = 1'b0;
  // Hold-off requests from the test sequence; the receiver serves them in order
  int   holdoff_reqs = 0;
  int   holdoff_done = 0;

  // ---------------------------------------------------------------------------
  // Arithmetic helpers
  // ---------------------------------------------------------------------------
  // p / 2^sh, nearest, halves away from zero
  function automatic longint round_half_away(input longint p, input int unsigned sh);
    bit     neg;
    longint m;
    neg = (p < 0);
    m   = neg ? -p : p;
    m   = (m + (longint'(1) << (sh - 1))) >> sh;
    return neg ? -m : m;
  endfunction

  // Limit plus a d-pad-scaled step, held to the 16-bit unsigned range
  function automatic logic [15:0] stepped_limit(input logic [15:0] lim,
                                                input logic [15:0] step,
                                                input logic signed [15:0] dpad);
    longint v;
    v = longint'(lim) + round_half_away(longint'(step) * longint'(dpad), 15);
    if (v < 0) v = 0;
    if (v > 65535) v = 65535;
    return v[15:0];
  endfunction

  // Advances the predicted state by one sample and returns the commands it yields
  function automatic cmd_t scale_sample(input sample_t s);
    cmd_t   r;
    int     dmag;
    int     pmag;
    logic   pressed;
    logic   rising;
    longint lc;
    longint ac;
    dmag    = (s.dpad < 0) ? -int'(s.dpad) : int'(s.dpad);
    pmag    = (dpad_prev_q < 0) ? -int'(dpad_prev_q) : int'(dpad_prev_q);
    pressed = (dmag > int'(HalfScale));
    rising  = pressed && (pmag < int'(HalfScale));

    // Step taken on a fresh press, or on every sample while repeating
    // (including the first released sample, since repeat is judged as held before)
    if (repeating_q || rising) begin
      if (s.btn[CrossBit])         ang_max_q = stepped_limit(ang_max_q, ang_fine_q, s.dpad);
      else if (s.btn[SquareBit])   ang_max_q = stepped_limit(ang_max_q, ang_coarse_q, s.dpad);
      else if (s.btn[CircleBit])   lin_max_q = stepped_limit(lin_max_q, lin_fine_q, s.dpad);
      else if (s.btn[TriangleBit]) lin_max_q = stepped_limit(lin_max_q, lin_coarse_q, s.dpad);
    end

    if (pressed) begin
      if (!repeating_q) begin
        if (hold_cnt_q > rpt_delay_q) repeating_q = 1'b1;
        else if (hold_cnt_q != HoldMax) hold_cnt_q = hold_cnt_q + 8'd1;
      end
    end else begin
      hold_cnt_q  = '0;
      repeating_q = 1'b0;
    end
    dpad_prev_q = s.dpad;

    lc = round_half_away(longint'(lin_max_q) * longint'(s.lin_stick), 15);
    ac = round_half_away(longint'(ang_max_q) * longint'(s.turn_stick) *
                         longint'(DegToMrad), 31);
    r.lin_cmd = lc[16:0];
    r.ang_cmd = ac[21:0];
    r.lin_now = lin_max_q;
    r.ang_now = ang_max_q;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic sample_t make_sample(input logic signed [15:0] dpad,
                                          input logic [3:0] btn,
                                          input logic signed [15:0] lin,
                                          input logic signed [15:0] turn);
    sample_t s;
    s.dpad       = dpad;
    s.btn        = btn;
    s.lin_stick  = lin;
    s.turn_stick = turn;
    return s;
  endfunction

  function automatic logic [15:0] rand16();
    return 16'($urandom());
  endfunction

  // Past half scale in either direction, full extremes included
  function automatic logic signed [15:0] pressed_dpad();
    int v;
    if ($urandom_range(0, 1) == 1) v = $urandom_range(16385, 32767);
    else v = -int'($urandom_range(16385, 32768));
    return 16'(v);
  endfunction

  // Half scale or below; exactly half scale turns up often since it is the boundary
  function automatic logic signed [15:0] released_dpad();
    int v;
    case ($urandom_range(0, 7))
      0:       v = 16384;
      1:       v = -16384;
      2:       v = 0;
      default: v = int'($urandom_range(0, 32768)) - 16384;
    endcase
    return 16'(v);
  endfunction

  function automatic void note_failure(input string msg);
    failures++;
    if (failures <= MaxReports) $display("%s", msg);
  endfunction

  // One sample request. Valid is only lowered during a random gap, so a
  // following call in the same step never lowers and raises it together.
  task automatic send_sample(input sample_t s);
    while (!tx_steady && $urandom_range(0, 99) < 38) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i        <= 1'b1;
    dpad_axis_i       <= s.dpad;
    cross_button_i    <= s.btn[CrossBit];
    square_button_i   <= s.btn[SquareBit];
    circle_button_i   <= s.btn[CircleBit];
    triangle_button_i <= s.btn[TriangleBit];
    linear_stick_i    <= s.lin_stick;
    turn_stick_i      <= s.turn_stick;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    pending_cmds.push_back(scale_sample(s));
    items_sent++;
  endtask

  // Must be called in the step the last request was taken
  task automatic wait_drain();
    in_valid_i <= 1'b0;
    while (pending_cmds.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [15:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      CFG_LIN_FINE:     lin_fine_q   = data;
      CFG_LIN_COARSE:   lin_coarse_q = data;
      CFG_ANG_FINE:     ang_fine_q   = data;
      CFG_ANG_COARSE:   ang_coarse_q = data;
      CFG_REPEAT_DELAY: rpt_delay_q  = data[7:0];
      default: ;  // unused index, block ignores it
    endcase
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Full register set, plus one write to an unused index with random data
  task automatic apply_setting(input logic [15:0] lf, input logic [15:0] lc,
                               input logic [15:0] af, input logic [15:0] ac,
                               input logic [15:0] rd);
    write_reg(CFG_LIN_FINE, lf);
    write_reg(CFG_LIN_COARSE, lc);
    write_reg(CFG_ANG_FINE, af);
    write_reg(CFG_ANG_COARSE, ac);
    write_reg(CFG_REPEAT_DELAY, rd);
    write_reg(3'(CFG_REPEAT_DELAY) + 3'($urandom_range(1, 3)), rand16());
    settings_done++;
  endtask

  // Press held for hold_len samples, then a short release. Buttons mostly
  // stay put while held so the step selection is exercised under repeat.
  task automatic run_gesture(input int hold_len);
    logic [3:0] btn;
    int         rel;
    btn = 4'($urandom_range(0, 15));
    for (int i = 0; i < hold_len; i++) begin
      if ($urandom_range(0, 4) == 0) btn = 4'($urandom_range(0, 15));
      send_sample(make_sample(pressed_dpad(), btn, rand16(), rand16()));
    end
    rel = $urandom_range(1, 3);
    for (int i = 0; i < rel; i++)
      send_sample(make_sample(released_dpad(), 4'($urandom_range(0, 15)),
                              rand16(), rand16()));
  endtask

  // Mostly press gestures, the rest raw noise samples
  task automatic run_items(input int n);
    int target;
    int hold_max;
    int burst;
    target = items_sent + n;
    while (items_sent < target) begin
      if ($urandom_range(0, 99) < 80) begin
        hold_max = (int'(rpt_delay_q) < 30) ? int'(rpt_delay_q) + 6 : 12;
        run_gesture($urandom_range(1, hold_max));
      end else begin
        burst = $urandom_range(1, 3);
        for (int i = 0; i < burst; i++)
          send_sample(make_sample(rand16(), 4'($urandom_range(0, 15)),
                                  rand16(), rand16()));
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  // Reset limits against the stick extremes, no d-pad activity
  task automatic test_sticks_at_reset();
    send_sample(make_sample(AxisZero, BtnNone, AxisMaxPos, AxisMaxNeg));
    send_sample(make_sample(AxisZero, BtnNone, AxisMaxNeg, AxisMaxPos));
    send_sample(make_sample(AxisZero, BtnNone, AxisZero, AxisZero));
  endtask

  // Exactly half scale is neither a press nor a release, so the following
  // full-scale sample is not a rising edge either
  task automatic test_half_scale_threshold();
    send_sample(make_sample(AxisHalf, BtnCross, rand16(), rand16()));
    send_sample(make_sample(AxisNegHalf, BtnCross, rand16(), rand16()));
    send_sample(make_sample(AxisMaxPos, BtnCross, rand16(), rand16()));
  endtask

  // Each button wins over the lower ones; no button means no step
  task automatic test_button_priority();
    send_sample(make_sample(AxisZero, BtnNone, rand16(), rand16()));
    send_sample(make_sample(AxisMaxPos, BtnCross | BtnSquare | BtnCircle | BtnTriangle,
                            rand16(), rand16()));
    send_sample(make_sample(AxisZero, BtnNone, rand16(), rand16()));
    send_sample(make_sample(AxisMaxNeg, BtnSquare | BtnCircle | BtnTriangle,
                            rand16(), rand16()));
    send_sample(make_sample(AxisZero, BtnNone, rand16(), rand16()));
    send_sample(make_sample(AxisAbove, BtnCircle | BtnTriangle, rand16(), rand16()));
    send_sample(make_sample(AxisZero, BtnNone, rand16(), rand16()));
    send_sample(make_sample(AxisNegAbove, BtnTriangle, rand16(), rand16()));
    send_sample(make_sample(AxisZero, BtnNone, rand16(), rand16()));
    send_sample(make_sample(AxisMaxPos, BtnNone, rand16(), rand16()));
  endtask

  // Repeat after one held sample, saturation at the top, clamp at zero, and the
  // extra step on the first released sample after repeat
  task automatic test_repeat_and_clamp();
    wait_drain();
    write_reg(CFG_REPEAT_DELAY, 16'd0);
    write_reg(CFG_LIN_COARSE, 16'hFFFF);
    send_sample(make_sample(AxisZero, BtnTriangle, rand16(), rand16()));
    send_sample(make_sample(AxisMaxPos, BtnTriangle, AxisMaxPos, rand16()));
    send_sample(make_sample(AxisMaxPos, BtnTriangle, AxisMaxNeg, rand16()));
    send_sample(make_sample(AxisMaxNeg, BtnTriangle, AxisMaxPos, rand16()));
    send_sample(make_sample(AxisHalf, BtnTriangle, AxisMaxNeg, rand16()));
    send_sample(make_sample(AxisHalf, BtnTriangle, rand16(), rand16()));
  endtask

  // Receiver stalls for a long stretch while the sender keeps offering, so
  // the queue fills and the input side is back-pressured
  task automatic test_output_hold_off();
    tx_steady = 1'b1;
    holdoff_reqs++;
    run_items(24);
    tx_steady = 1'b0;
  endtask

  // Several register settings, extremes included, each followed by random traffic
  task automatic test_random_settings();
    for (int phase = 0; phase < 6; phase++) begin
      wait_drain();
      case (phase)
        0: apply_setting(16'($urandom_range(0, 2000)), 16'($urandom_range(0, 2000)),
                         16'($urandom_range(0, 2000)), 16'($urandom_range(0, 2000)),
                         16'($urandom_range(0, 30)));
        1: apply_setting(16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
        2: apply_setting(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        3: begin
          // no idling on either side for this whole phase
          tx_steady = 1'b1;
          rx_steady = 1'b1;
          apply_setting(rand16(), rand16(), rand16(), rand16(),
                        16'($urandom_range(0, 5)));
        end
        4: apply_setting(rand16(), rand16(), rand16(), rand16(), rand16());
        default: apply_setting(LinFineRst, LinCoarseRst, AngFineRst, AngCoarseRst,
                               16'(RepeatDelayRst));
      endcase
      // hold count saturates at its maximum; with the largest delay repeat never starts
      if (phase == 2) run_gesture(270);
      run_items(200);
      tx_steady = 1'b0;
      rx_steady = 1'b0;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: random ready, with hold-off stretches served on request
  // ---------------------------------------------------------------------------
  initial begin
    out_ready_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (holdoff_reqs != holdoff_done) begin
        holdoff_done++;
        out_ready_i <= 1'b0;
        for (int c = 0; c < HoldOffCycles; c++) @(posedge clk_i);
      end
      out_ready_i <= (rx_steady || $urandom_range(0, 99) >= 38);
    end
  end

  // ---------------------------------------------------------------------------
  // Result checker: every taken result against the oldest prediction
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : result_check
    cmd_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_cmds.size() == 0) begin
        note_failure($sformatf("unexpected result: lin %0d ang %0d lnow %0d anow %0d",
                               linear_command_o, angular_command_o,
                               linear_limit_now_o, angular_limit_now_o));
      end else begin
        want = pending_cmds.pop_front();
        results_checked++;
        if (want.lin_cmd !== linear_command_o || want.ang_cmd !== angular_command_o ||
            want.lin_now !== linear_limit_now_o || want.ang_now !== angular_limit_now_o) begin
          note_failure($sformatf(
            "mismatch at result %0d: exp lin %0d ang %0d lnow %0d anow %0d, got %0d %0d %0d %0d",
            results_checked, want.lin_cmd, want.ang_cmd, want.lin_now, want.ang_now,
            linear_command_o, angular_command_o, linear_limit_now_o, angular_limit_now_o));
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog: ends the run if no request moves on any channel for too long
  // ---------------------------------------------------------------------------
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QuietLimit) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
          (cfg_valid_i && cfg_ready_o))
        quiet = 0;
      else
        quiet++;
    end
    $display("watchdog: no request accepted for %0d cycles", QuietLimit);
    $display("TEST FAILED");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    // every input known from time zero, with reset asserted at the start
    rst_ni            = 1'b0;
    cfg_valid_i       = 1'b0;
    cfg_index_i       = '0;
    cfg_data_i        = '0;
    in_valid_i        = 1'b0;
    dpad_axis_i       = '0;
    cross_button_i    = 1'b0;
    square_button_i   = 1'b0;
    circle_button_i   = 1'b0;
    triangle_button_i = 1'b0;
    linear_stick_i    = '0;
    turn_stick_i      = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_sticks_at_reset();
    test_half_scale_threshold();
    test_button_priority();
    test_repeat_and_clamp();
    test_output_hold_off();
    test_random_settings();

    wait_drain();
    if (pending_cmds.size() != 0)
      note_failure($sformatf("%0d predicted results never arrived", pending_cmds.size()));

    $display("Covered %0d samples and %0d checked results across %0d register settings,",
             items_sent, results_checked, settings_done);
    $display("incl. half-scale edges, auto-repeat, limit clamping and a long output stall.");
    if (failures == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0d failures", failures);
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

FILE: sim.f
hdl/jrls_pkg.sv
hdl/jrls_front.sv
hdl/jrls_queue.sv
hdl/jrls_back.sv
hdl/joystick_rate_limit_scaler_top.sv
tb/tb_joystick_rate_limit_scaler_top.sv
